/* rtl/core/saq_pkg.sv */
`default_nettype none

package saq_pkg;

   localparam int TIME_WIDTH = 32;

   localparam int ANGLE_WIDTH  = 16;
   localparam int RATE_WIDTH   = 19;
   localparam int WINDOW_WIDTH = 15;
   localparam int MAXRATE_WIDTH = 18;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   // request tdata layout, lowest bit first
   localparam int REQ_NOW_LSB      = 0;
   localparam int REQ_ANGLE_LSB    = REQ_NOW_LSB + TIME_WIDTH;
   localparam int REQ_RATE_LSB     = REQ_ANGLE_LSB + ANGLE_WIDTH;
   localparam int REQ_FRESH_LSB    = REQ_RATE_LSB + RATE_WIDTH;
   localparam int REQ_COOLDOWN_LSB = REQ_FRESH_LSB + 1;
   localparam int REQ_USED_BITS    = REQ_COOLDOWN_LSB + TIME_WIDTH;
   localparam int REQ_DATA_WIDTH   = ((REQ_USED_BITS + 7) / 8) * 8;

   localparam int RSP_DATA_WIDTH = 8;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ANGLE_WINDOW = 2'd0,
      CSR_MAX_RATE     = 2'd1,
      CSR_STILL_TIME   = 2'd2,
      CSR_TARGET_ANGLE = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_SAMPLE   = 1'b0,
      CMD_SUPPRESS = 1'b1
   } command_type;

endpackage

`default_nettype wire

/* rtl/core/stillness_arm_qualifier.sv */
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser: command; tdata: sample fields
// rsp      out        rsp_tvalid/rsp_tready  tdata: armed
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One request per cycle while req_tready is high: each request is evaluated in the
// cycle it is accepted against the held candidate/cooldown state, and its response
// is registered; rsp_tvalid rises in the cycle after a request is accepted.
// Reset clears config, candidate and cooldown state and the response register.
// req_tready is low while a response waits and rsp_tready is low, and while
// csr_valid is high. csr_ready is always high; any config write clears the candidate.

module stillness_arm_qualifier
   import saq_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // [31:0] now_ms, [47:32] angle_cdeg, [66:48] rate_cdps, [67] gyro_fresh,
   // [99:68] cooldown_ms, [103:100] zero
   input  wire logic [REQ_DATA_WIDTH-1:0]  req_tdata,
   // [0] command
   input  wire logic                       req_tuser,

   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // [0] armed, [7:1] zero
   output logic [RSP_DATA_WIDTH-1:0]       rsp_tdata,

   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   logic [WINDOW_WIDTH-1:0]  angle_window_ff;
   logic [MAXRATE_WIDTH-1:0] max_rate_ff;
   logic [TIME_WIDTH-1:0]    still_time_ff;
   logic signed [ANGLE_WIDTH-1:0] target_angle_ff;

   logic                  have_candidate_ff, have_candidate_in;
   logic [TIME_WIDTH-1:0] candidate_start_ff, candidate_start_in;
   logic                  suppress_active_ff, suppress_active_in;
   logic [TIME_WIDTH-1:0] suppress_until_ff, suppress_until_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic armed_ff, armed_in;

   logic req_fire, csr_fire;
   command_type           command;
   logic [TIME_WIDTH-1:0] now_ms;
   logic signed [ANGLE_WIDTH-1:0] angle_cdeg;
   logic signed [RATE_WIDTH-1:0]  rate_cdps;
   logic                  gyro_fresh;
   logic [TIME_WIDTH-1:0] cooldown_ms;

   logic signed [ANGLE_WIDTH:0] angle_err;
   logic [ANGLE_WIDTH:0]        angle_mag;
   logic [RATE_WIDTH-1:0]       rate_mag;
   logic [TIME_WIDTH-1:0]       cool_diff;
   logic [TIME_WIDTH-1:0]       elapsed;
   logic                        still;

   // a config write takes the cycle; the request waits
   assign req_tready = (!rsp_valid_ff || rsp_tready) && !csr_valid;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid;

   assign command     = command_type'(req_tuser);
   assign now_ms      = req_tdata[REQ_NOW_LSB +: TIME_WIDTH];
   assign angle_cdeg  = req_tdata[REQ_ANGLE_LSB +: ANGLE_WIDTH];
   assign rate_cdps   = req_tdata[REQ_RATE_LSB +: RATE_WIDTH];
   assign gyro_fresh  = req_tdata[REQ_FRESH_LSB];
   assign cooldown_ms = req_tdata[REQ_COOLDOWN_LSB +: TIME_WIDTH];

   // 17-bit signed error; magnitude of the most negative value still fits unsigned
   assign angle_err = {angle_cdeg[ANGLE_WIDTH-1], angle_cdeg} -
                      {target_angle_ff[ANGLE_WIDTH-1], target_angle_ff};
   assign angle_mag = angle_err[ANGLE_WIDTH] ? (ANGLE_WIDTH+1)'(-angle_err) :
                                               (ANGLE_WIDTH+1)'(angle_err);
   assign rate_mag  = rate_cdps[RATE_WIDTH-1] ? RATE_WIDTH'(-rate_cdps) :
                                                RATE_WIDTH'(rate_cdps);

   assign still = gyro_fresh &&
                  (angle_mag <= {{(ANGLE_WIDTH+1-WINDOW_WIDTH){1'b0}}, angle_window_ff}) &&
                  (rate_mag <= {{(RATE_WIDTH-MAXRATE_WIDTH){1'b0}}, max_rate_ff});

   // wrap-safe cooldown check: sign of the modular difference
   assign cool_diff = now_ms - suppress_until_ff;
   assign elapsed   = have_candidate_ff ? (now_ms - candidate_start_ff) : '0;

   always_comb begin
      have_candidate_in  = have_candidate_ff;
      candidate_start_in = candidate_start_ff;
      suppress_active_in = suppress_active_ff;
      suppress_until_in  = suppress_until_ff;
      armed_in           = armed_ff;
      rsp_valid_in       = rsp_valid_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_fire) begin
         have_candidate_in  = 1'b0;
         candidate_start_in = '0;
      end else if (req_fire) begin
         rsp_valid_in = 1'b1;
         armed_in     = 1'b0;
         if (command == CMD_SUPPRESS) begin
            suppress_until_in  = now_ms + cooldown_ms;
            suppress_active_in = 1'b1;
            have_candidate_in  = 1'b0;
            candidate_start_in = '0;
         end else if (suppress_active_ff && cool_diff[TIME_WIDTH-1]) begin
            have_candidate_in  = 1'b0;
            candidate_start_in = '0;
         end else begin
            suppress_active_in = 1'b0;
            if (!still) begin
               have_candidate_in  = 1'b0;
               candidate_start_in = '0;
            end else begin
               if (!have_candidate_ff) begin
                  have_candidate_in  = 1'b1;
                  candidate_start_in = now_ms;
               end
               armed_in = (elapsed >= still_time_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_window_ff    <= '0;
         max_rate_ff        <= '0;
         still_time_ff      <= '0;
         target_angle_ff    <= '0;
         have_candidate_ff  <= 1'b0;
         candidate_start_ff <= '0;
         suppress_active_ff <= 1'b0;
         suppress_until_ff  <= '0;
         rsp_valid_ff       <= 1'b0;
         armed_ff           <= 1'b0;
      end else begin
         have_candidate_ff  <= have_candidate_in;
         candidate_start_ff <= candidate_start_in;
         suppress_active_ff <= suppress_active_in;
         suppress_until_ff  <= suppress_until_in;
         rsp_valid_ff       <= rsp_valid_in;
         armed_ff           <= armed_in;
         if (csr_fire) begin
            case (csr_index_type'(csr_index))
               CSR_ANGLE_WINDOW: angle_window_ff <= csr_data[WINDOW_WIDTH-1:0];
               CSR_MAX_RATE:     max_rate_ff     <= csr_data[MAXRATE_WIDTH-1:0];
               CSR_STILL_TIME:   still_time_ff   <= csr_data[TIME_WIDTH-1:0];
               CSR_TARGET_ANGLE: target_angle_ff <= csr_data[ANGLE_WIDTH-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-1){1'b0}}, armed_ff};

   a_csr_clears_candidate: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> !have_candidate_ff)
      else $error("config write left a candidate");

   a_suppress_not_armed: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser && !csr_fire) |=> (rsp_tvalid && !rsp_tdata[0] &&
                                                suppress_active_ff))
      else $error("suppress request did not start cooldown or reported armed");

   a_armed_has_candidate: assert property (@(posedge clock) disable iff (reset)
      (req_fire && armed_in && !csr_fire) |=> (have_candidate_ff &&
                                               !suppress_active_ff))
      else $error("armed without a held candidate");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_tdata[0] == $past(armed_ff)))
      else $error("response overwritten while stalled");

endmodule

`default_nettype wire

/* tb/stillness_arm_qualifier_tb.sv */
`default_nettype none

module stillness_arm_qualifier_tb;
   import saq_pkg::*;

   localparam int REQ_PAD     = REQ_DATA_WIDTH - REQ_USED_BITS;
   localparam int CYCLE_LIMIT = 200000;

   // first member lands in the top bits, so now_ms ends up at bit 0
   typedef struct packed {
      logic [TIME_WIDTH-1:0]         cooldown_ms;
      logic                          gyro_fresh;
      logic signed [RATE_WIDTH-1:0]  rate_cdps;
      logic signed [ANGLE_WIDTH-1:0] angle_cdeg;
      logic [TIME_WIDTH-1:0]         now_ms;
   } sample_fields_t;

   class arm_scoreboard;
      logic [WINDOW_WIDTH-1:0]        angle_window    = '0;
      logic [MAXRATE_WIDTH-1:0]       max_rate        = '0;
      logic [TIME_WIDTH-1:0]          still_time      = '0;
      logic signed [ANGLE_WIDTH-1:0]  target_angle    = '0;
      bit                             have_candidate  = 1'b0;
      logic [TIME_WIDTH-1:0]          candidate_start = '0;
      bit                             suppress_active = 1'b0;
      logic [TIME_WIDTH-1:0]          suppress_until  = '0;
      logic [RSP_DATA_WIDTH-1:0]      armed_q[$];
      int                             failures        = 0;

      function void drop_candidate();
         have_candidate  = 1'b0;
         candidate_start = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
         case (idx)
            CSR_ANGLE_WINDOW: angle_window = value[WINDOW_WIDTH-1:0];
            CSR_MAX_RATE:     max_rate     = value[MAXRATE_WIDTH-1:0];
            CSR_STILL_TIME:   still_time   = value[TIME_WIDTH-1:0];
            CSR_TARGET_ANGLE: target_angle = value[ANGLE_WIDTH-1:0];
            default: ;
         endcase
         drop_candidate();
      endfunction

      function void note_request(command_type cmd, sample_fields_t f);
         logic [TIME_WIDTH-1:0] lag;
         int                    tilt_err;
         int                    rate_mag;
         bit                    armed;
         armed = 1'b0;
         lag   = f.now_ms - suppress_until;
         if (cmd == CMD_SUPPRESS) begin
            suppress_until  = f.now_ms + f.cooldown_ms;
            suppress_active = 1'b1;
            drop_candidate();
         end else if (suppress_active && lag[TIME_WIDTH-1]) begin
            drop_candidate();
         end else begin
            suppress_active = 1'b0;
            tilt_err = int'($signed(f.angle_cdeg)) - int'($signed(target_angle));
            if (tilt_err < 0) tilt_err = -tilt_err;
            rate_mag = int'($signed(f.rate_cdps));
            if (rate_mag < 0) rate_mag = -rate_mag;
            if (f.gyro_fresh && tilt_err <= int'(angle_window) && rate_mag <= int'(max_rate)) begin
               if (!have_candidate) begin
                  candidate_start = f.now_ms;
                  have_candidate  = 1'b1;
               end
               armed = (f.now_ms - candidate_start) >= still_time;
            end else begin
               drop_candidate();
            end
         end
         armed_q.push_back(RSP_DATA_WIDTH'(armed));
      endfunction

      function void check_response(logic [RSP_DATA_WIDTH-1:0] got);
         logic [RSP_DATA_WIDTH-1:0] want;
         if (armed_q.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual %h", $time, got);
            failures++;
            return;
         end
         want = armed_q.pop_front();
         if (got !== want) begin
            $display("%0t: armed mismatch: expected %h, actual %h", $time, want, got);
            failures++;
         end
      endfunction

      function int pending();
         return armed_q.size();
      endfunction
   endclass

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_WIDTH-1:0]  req_tdata  = '0;
   logic                       req_tuser  = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data   = '0;

   arm_scoreboard         sb;
   int                    req_idle_pct = 36;
   int                    rsp_idle_pct = 71;
   int                    cycle_count  = 0;
   logic [TIME_WIDTH-1:0] base_ms      = '0;

   stillness_arm_qualifier u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("stillness_arm_qualifier test failed");
         $finish;
      end
   end

   // valid stays up between back-to-back requests; it only drops on an idle cycle
   task automatic send_req(input command_type cmd, input logic [TIME_WIDTH-1:0] now,
                           input logic [ANGLE_WIDTH-1:0] angle,
                           input logic [RATE_WIDTH-1:0] rate, input logic fresh,
                           input logic [TIME_WIDTH-1:0] cooldown);
      sample_fields_t f;
      f.now_ms      = now;
      f.angle_cdeg  = angle;
      f.rate_cdps   = rate;
      f.gyro_fresh  = fresh;
      f.cooldown_ms = cooldown;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{REQ_PAD{1'b0}}, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(cmd, f);
   endtask

   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic apply_settings(input logic [31:0] window, input logic [31:0] rate_limit,
                                 input logic [31:0] hold_ms, input logic [31:0] target);
      write_reg(CSR_ANGLE_WINDOW, window);
      write_reg(CSR_MAX_RATE, rate_limit);
      write_reg(CSR_STILL_TIME, hold_ms);
      write_reg(CSR_TARGET_ANGLE, target);
      csr_valid <= 1'b0;
   endtask

   // mostly plausible samples on a slowly advancing clock, plus suppress and noise
   task automatic random_request();
      command_type       cmd;
      int                pick;
      int                span;
      int                angle;
      int                rate;
      logic [31:0]       cooldown;
      logic              fresh;
      pick     = $urandom_range(0, 99);
      cooldown = $urandom;
      fresh    = ($urandom_range(0, 15) != 0);
      cmd      = CMD_SAMPLE;
      if (pick < 6) begin
         cmd = CMD_SUPPRESS;
         if ($urandom_range(0, 3) != 0) cooldown = $urandom_range(0, 80);
         send_req(cmd, base_ms, ANGLE_WIDTH'($urandom), RATE_WIDTH'($urandom),
                  1'($urandom), cooldown);
      end else if (pick < 14) begin
         send_req(cmd, $urandom, ANGLE_WIDTH'($urandom), RATE_WIDTH'($urandom),
                  1'($urandom), cooldown);
      end else begin
         if ($urandom_range(0, 49) == 0) base_ms += $urandom;
         else base_ms += $urandom_range(0, 12);
         span  = int'(sb.angle_window) + 2;
         angle = int'($signed(sb.target_angle)) + int'($urandom_range(0, 2 * span)) - span;
         if (angle > 18000) angle = 18000;
         if (angle < -18000) angle = -18000;
         span = int'(sb.max_rate) + 2;
         rate = int'($urandom_range(0, 2 * span)) - span;
         if (rate > 200000) rate = 200000;
         if (rate < -200000) rate = -200000;
         send_req(cmd, base_ms, angle[15:0], rate[18:0], fresh, cooldown);
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset config: zero window, zero rate limit, zero hold time
      send_req(CMD_SAMPLE, 32'd0, 16'd0, 19'd0, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'hFFFF_FFFF, 16'd0, 19'd0, 1'b0, 32'hFFFF_FFFF);
      send_req(CMD_SAMPLE, 32'd5, 16'd1, 19'd0, 1'b1, 32'd0);

      quiesce();
      apply_settings(500, 1000, 20, -300);
      send_req(CMD_SAMPLE, 32'd1000, -16'sd300, 19'd0, 1'b1, 32'd7);
      send_req(CMD_SAMPLE, 32'd1010, 16'd200, 19'd1000, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'd1020, -16'sd800, -19'sd1000, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'd1030, 16'd201, 19'd0, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'd1040, -16'sd300, 19'd1001, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'd1050, -16'sd300, -19'sd1001, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'd1060, -16'sd300, 19'd0, 1'b1, 32'd0);

      // a register write in the middle of a candidate restarts it
      quiesce();
      write_reg(CSR_STILL_TIME, 10);
      csr_valid <= 1'b0;
      send_req(CMD_SAMPLE, 32'd1070, -16'sd300, 19'd0, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'd1080, -16'sd300, 19'd0, 1'b1, 32'd0);
      send_req(CMD_SUPPRESS, 32'd1090, 16'd0, 19'd0, 1'b0, 32'd100);
      send_req(CMD_SAMPLE, 32'd1189, -16'sd300, 19'd0, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'd1190, -16'sd300, 19'd0, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'd1200, -16'sd300, 19'd0, 1'b1, 32'd0);
      // cooldown end wraps past zero
      send_req(CMD_SUPPRESS, 32'hFFFF_FFF0, 16'd0, 19'd0, 1'b1, 32'h20);
      send_req(CMD_SAMPLE, 32'hFFFF_FFFF, -16'sd300, 19'd0, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'h10, -16'sd300, 19'd0, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'h1A, -16'sd300, 19'd0, 1'b1, 32'd0);
      // candidate elapsed time wraps
      send_req(CMD_SAMPLE, 32'h20, 16'sd18000, 19'd0, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'hFFFF_FFFC, -16'sd300, 19'd0, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'h6, -16'sd300, 19'd0, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'h7, -16'sd18000, 19'd0, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'h8, -16'sd300, 19'sd200000, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'h9, -16'sd300, -19'sd200000, 1'b1, 32'd0);
      // longest cooldown: signed difference sits right at the sign boundary
      send_req(CMD_SUPPRESS, 32'd0, 16'd0, 19'd0, 1'b0, 32'hFFFF_FFFF);
      send_req(CMD_SAMPLE, 32'h7FFF_FFFF, -16'sd300, 19'd0, 1'b1, 32'd0);
      send_req(CMD_SAMPLE, 32'h7FFF_FFFE, -16'sd300, 19'd0, 1'b1, 32'd0);

      for (int phase = 0; phase < 6; phase++) begin
         quiesce();
         case (phase)
            0: apply_settings(300, 2000, 30, 0);
            1: apply_settings(18000, 200000, 0, 18000);
            2: apply_settings(0, 0, 32'hFFFF_FFFF, -18000);
            3: apply_settings(1000, 50000, 5, -1234);
            4: apply_settings($urandom, $urandom, $urandom_range(0, 40), $urandom);
            default: apply_settings(200, 500, 60, 4000);
         endcase
         req_idle_pct = (phase < 2) ? 36 : (phase < 4) ? 71 : 0;
         rsp_idle_pct = (phase < 2) ? 71 : (phase < 4) ? 36 : 0;
         base_ms = $urandom;
         repeat (67) random_request();
      end

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.failures == 0) begin
         $display("stillness_arm_qualifier test passed");
      end else begin
         $display("stillness_arm_qualifier test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
